FILE: design/csm_pkg.sv
// ----------------------------------------------------------------------------
// csm_pkg
// Shared types and constants of the checked stack machine executor.
// ----------------------------------------------------------------------------
package csm_pkg;

    localparam int STACK_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int VAL_W       = 31;
    localparam int IN_W        = 30;
    localparam int LIMIT_W     = 30;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 30'd1000000000;

    typedef enum logic [3:0] {
        KIND_START  = 4'd0,
        KIND_PUSH   = 4'd1,
        KIND_POP    = 4'd2,
        KIND_NEG    = 4'd3,
        KIND_DUP    = 4'd4,
        KIND_SWAP   = 4'd5,
        KIND_ADD    = 4'd6,
        KIND_SUB    = 4'd7,
        KIND_MUL    = 4'd8,
        KIND_DIV    = 4'd9,
        KIND_MOD    = 4'd10,
        KIND_FINISH = 4'd11
    } t_kind;

    typedef struct packed {
        logic [3:0]      kind;
        logic [IN_W-1:0] value;
    } t_in;

    typedef struct packed {
        logic signed [VAL_W-1:0] result_value;
        logic                    error;
    } t_out;

    // Classified instruction handed from the front to the back.
    typedef struct packed {
        t_kind           kind;
        logic [IN_W-1:0] value;
        logic            need1;
        logic            need2;
        logic            grow;
    } t_cmd;

endpackage

FILE: design/csm_ram.sv
// ----------------------------------------------------------------------------
// csm_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module csm_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: design/csm_front.sv
// ----------------------------------------------------------------------------
// csm_front
// Accepts input words, classifies them, and holds the known kinds in a two-entry queue.
// ----------------------------------------------------------------------------
module csm_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  csm_pkg::t_in  i_data,
    output logic          o_ready,
    output logic          o_cmd_valid,
    output csm_pkg::t_cmd o_cmd,
    input  logic          i_cmd_pop
);
    import csm_pkg::*;

    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_cmd       w_cmd;
    logic       w_keep;
    logic       w_push;

    always_comb begin
        w_cmd.kind  = KIND_START;
        w_cmd.value = i_data.value;
        w_cmd.need1 = 1'b0;
        w_cmd.need2 = 1'b0;
        w_cmd.grow  = 1'b0;
        w_keep      = 1'b1;
        unique case (i_data.kind)
            KIND_START:  w_cmd.kind = KIND_START;
            KIND_PUSH:   begin w_cmd.kind = KIND_PUSH; w_cmd.grow = 1'b1; end
            KIND_POP:    begin w_cmd.kind = KIND_POP;  w_cmd.need1 = 1'b1; end
            KIND_NEG:    begin w_cmd.kind = KIND_NEG;  w_cmd.need1 = 1'b1; end
            KIND_DUP:    begin
                w_cmd.kind = KIND_DUP; w_cmd.need1 = 1'b1; w_cmd.grow = 1'b1;
            end
            KIND_SWAP:   begin w_cmd.kind = KIND_SWAP; w_cmd.need2 = 1'b1; end
            KIND_ADD:    begin w_cmd.kind = KIND_ADD;  w_cmd.need2 = 1'b1; end
            KIND_SUB:    begin w_cmd.kind = KIND_SUB;  w_cmd.need2 = 1'b1; end
            KIND_MUL:    begin w_cmd.kind = KIND_MUL;  w_cmd.need2 = 1'b1; end
            KIND_DIV:    begin w_cmd.kind = KIND_DIV;  w_cmd.need2 = 1'b1; end
            KIND_MOD:    begin w_cmd.kind = KIND_MOD;  w_cmd.need2 = 1'b1; end
            KIND_FINISH: w_cmd.kind = KIND_FINISH;
            // Unused codes are accepted and dropped here.
            default:     w_keep = 1'b0;
        endcase
    end

    assign o_ready     = (r_cnt != 2'd2);
    assign w_push      = i_valid && o_ready && w_keep;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_q[r_wp] <= w_cmd;
                r_wp      <= ~r_wp;
            end
            if (i_cmd_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_cmd_pop);
        end
    end
endmodule

FILE: design/csm_div.sv
// ----------------------------------------------------------------------------
// csm_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module csm_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [csm_pkg::VAL_W-1:0]   i_dividend,
    input  logic [csm_pkg::VAL_W-1:0]   i_divisor,
    output logic                        o_done,
    output logic [csm_pkg::VAL_W-1:0]   o_quo,
    output logic [csm_pkg::VAL_W-1:0]   o_rem
);
    import csm_pkg::*;

    localparam int STEP_W = $clog2(VAL_W);

    logic              r_busy, r_done;
    logic [STEP_W-1:0] r_step;
    logic [VAL_W-1:0]  r_quo, r_div;
    logic [VAL_W:0]    r_rem;
    logic [VAL_W:0]    w_sh;
    logic              w_ge;

    assign w_sh = {r_rem[VAL_W-1:0], r_quo[VAL_W-1]};
    assign w_ge = (w_sh >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(VAL_W - 1);
                r_quo  <= i_dividend;
                r_div  <= i_divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem  <= w_ge ? (w_sh - {1'b0, r_div}) : w_sh;
                r_quo  <= {r_quo[VAL_W-2:0], w_ge};
                r_step <= r_step - STEP_W'(1);
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem[VAL_W-1:0];
endmodule

FILE: design/csm_back.sv
// ----------------------------------------------------------------------------
// csm_back
// Executes classified instructions on the stack and drives the result word.
// ----------------------------------------------------------------------------
module csm_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cmd_valid,
    input  csm_pkg::t_cmd                 i_cmd,
    output logic                          o_cmd_pop,
    input  logic [csm_pkg::LIMIT_W-1:0]   i_limit,
    output logic                          o_valid,
    output csm_pkg::t_out                 o_data,
    input  logic                          i_ready
);
    import csm_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_DIV, ST_LOAD} t_state;

    t_state r_state, n_state;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic signed [VAL_W-1:0] r_tos, n_tos, r_nos, n_nos;
    logic                    r_fault, n_fault;
    logic                    r_mod, n_mod, r_sa, n_sa, r_sb, n_sb;
    logic signed [2*VAL_W-1:0] r_prod, n_prod;
    logic                    r_ovalid, n_ovalid;
    t_out                    r_out, n_out;

    logic                    w_we, w_re, w_dstart, w_ddone;
    logic [ADDR_W-1:0]       w_waddr, w_raddr;
    logic [VAL_W-1:0]        w_rdata, w_dq, w_dr, w_abs_a, w_abs_b, w_mag;
    logic                    w_commit, w_big, w_under, w_over, w_neg;
    logic signed [VAL_W-1:0] w_res, w_push_val;
    logic signed [VAL_W+1:0] w_sum, w_lim33;
    logic signed [2*VAL_W-1:0] w_lim62;

    csm_ram #(.WIDTH(VAL_W), .DEPTH(STACK_DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(r_nos),
        .i_re   (w_re),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    csm_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_dstart),
        .i_dividend(w_abs_a),
        .i_divisor (w_abs_b),
        .o_done    (w_ddone),
        .o_quo     (w_dq),
        .o_rem     (w_dr)
    );

    assign w_abs_a = r_nos[VAL_W-1] ? VAL_W'(-r_nos) : r_nos;
    assign w_abs_b = r_tos[VAL_W-1] ? VAL_W'(-r_tos) : r_tos;
    assign w_lim33 = $signed({2'b00, 1'b0, i_limit});
    assign w_lim62 = $signed({{(2*VAL_W-LIMIT_W){1'b0}}, i_limit});
    assign w_sum   = (i_cmd.kind == KIND_SUB)
                   ? (VAL_W+2)'(r_nos) - (VAL_W+2)'(r_tos)
                   : (VAL_W+2)'(r_nos) + (VAL_W+2)'(r_tos);
    assign w_mag   = r_mod ? w_dr : w_dq;
    assign w_neg   = r_mod ? r_sa : (r_sa ^ r_sb);
    assign w_under = (i_cmd.need1 && r_cnt == '0) || (i_cmd.need2 && r_cnt < CNT_W'(2));
    assign w_over  = i_cmd.grow && (r_cnt == CNT_W'(STACK_DEPTH));
    assign w_push_val = (i_cmd.kind == KIND_PUSH) ? $signed({1'b0, i_cmd.value}) : r_tos;
    assign w_waddr = ADDR_W'(r_cnt - CNT_W'(2));
    assign w_raddr = ADDR_W'(r_cnt - CNT_W'(3));

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_tos    = r_tos;
        n_nos    = r_nos;
        n_fault  = r_fault;
        n_mod    = r_mod;
        n_sa     = r_sa;
        n_sb     = r_sb;
        n_prod   = r_prod;
        n_ovalid = r_ovalid && !i_ready;
        n_out    = r_out;
        o_cmd_pop = 1'b0;
        w_we     = 1'b0;
        w_re     = 1'b0;
        w_dstart = 1'b0;
        w_commit = 1'b0;
        w_big    = 1'b0;
        w_res    = r_tos;

        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    if (i_cmd.kind == KIND_FINISH) begin
                        if (!n_ovalid) begin
                            o_cmd_pop = 1'b1;
                            n_ovalid  = 1'b1;
                            if (r_fault || r_cnt != CNT_W'(1)) begin
                                n_out.result_value = '0;
                                n_out.error        = 1'b1;
                            end else begin
                                n_out.result_value = r_tos;
                                n_out.error        = 1'b0;
                            end
                        end
                    end else begin
                        o_cmd_pop = 1'b1;
                        if (i_cmd.kind == KIND_START) begin
                            n_fault = 1'b0;
                            n_cnt   = CNT_W'(1);
                            n_tos   = $signed({1'b0, i_cmd.value});
                        end else if (!r_fault) begin
                            if (w_under || w_over) begin
                                n_fault = 1'b1;
                            end else begin
                                unique case (i_cmd.kind)
                                    KIND_PUSH, KIND_DUP: begin
                                        w_we  = (r_cnt >= CNT_W'(2));
                                        n_nos = r_tos;
                                        n_tos = w_push_val;
                                        n_cnt = r_cnt + CNT_W'(1);
                                    end
                                    KIND_POP: begin
                                        n_tos = r_nos;
                                        n_cnt = r_cnt - CNT_W'(1);
                                        if (r_cnt >= CNT_W'(3)) begin
                                            w_re    = 1'b1;
                                            n_state = ST_LOAD;
                                        end
                                    end
                                    KIND_NEG: n_tos = -r_tos;
                                    KIND_SWAP: begin
                                        n_tos = r_nos;
                                        n_nos = r_tos;
                                    end
                                    KIND_ADD, KIND_SUB: begin
                                        w_commit = 1'b1;
                                        w_res    = VAL_W'(w_sum);
                                        w_big    = (w_sum > w_lim33) || (w_sum < -w_lim33);
                                    end
                                    KIND_MUL: begin
                                        n_prod  = r_nos * r_tos;
                                        n_state = ST_MUL;
                                    end
                                    KIND_DIV, KIND_MOD: begin
                                        if (r_tos == '0) begin
                                            n_fault = 1'b1;
                                        end else begin
                                            w_dstart = 1'b1;
                                            n_mod    = (i_cmd.kind == KIND_MOD);
                                            n_sa     = r_nos[VAL_W-1];
                                            n_sb     = r_tos[VAL_W-1];
                                            n_state  = ST_DIV;
                                        end
                                    end
                                    default: ;
                                endcase
                            end
                        end
                    end
                end
            end
            ST_MUL: begin
                w_commit = 1'b1;
                w_res    = VAL_W'(r_prod);
                w_big    = (r_prod > w_lim62) || (r_prod < -w_lim62);
            end
            ST_DIV: begin
                if (w_ddone) begin
                    w_commit = 1'b1;
                    w_res    = w_neg ? VAL_W'(-w_mag) : w_mag;
                    w_big    = (w_mag > {1'b0, i_limit});
                end
            end
            ST_LOAD: begin
                n_nos   = w_rdata;
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase

        // A binary result replaces both operands; RAM gives any new second entry.
        if (w_commit) begin
            n_state = ST_IDLE;
            if (w_big) begin
                n_fault = 1'b1;
            end else begin
                n_tos = w_res;
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt >= CNT_W'(3)) begin
                    w_re    = 1'b1;
                    n_state = ST_LOAD;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_fault  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_fault  <= n_fault;
            r_ovalid <= n_ovalid;
        end
        r_tos  <= n_tos;
        r_nos  <= n_nos;
        r_mod  <= n_mod;
        r_sa   <= n_sa;
        r_sb   <= n_sb;
        r_prod <= n_prod;
        r_out  <= n_out;
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_out;
endmodule

FILE: design/checked_stack_machine_executor.sv
// A word is registered in the queue, then executed; a pop or binary result
// reloads the second entry from RAM in a load state when RAM holds one; MUL
// passes a multiply state and DIV and MOD wait on the one-bit-per-cycle
// divider. A finish word is on the output the cycle after the executor takes
// it; words are run one at a time. Synchronous active-low reset empties
// the stack, clears the error flag and sets the magnitude limit to 1000000000.
// ----------------------------------------------------------------------------
// checked_stack_machine_executor
// Streamed stack machine with checked arithmetic and a latched error flag.
// ----------------------------------------------------------------------------
module checked_stack_machine_executor (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  csm_pkg::t_in                  i_data,
    output logic                          o_ready,
    output logic                          o_valid,
    output csm_pkg::t_out                 o_data,
    input  logic                          i_ready,
    input  logic                          i_cfg_we,
    input  logic [csm_pkg::LIMIT_W-1:0]   i_cfg_wdata
);
    import csm_pkg::*;

    logic [LIMIT_W-1:0] r_limit;
    logic               w_cmd_valid, w_cmd_pop;
    t_cmd               w_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_wdata;
        end
    end

    csm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_data     (i_data),
        .o_ready    (o_ready),
        .o_cmd_valid(w_cmd_valid),
        .o_cmd      (w_cmd),
        .i_cmd_pop  (w_cmd_pop)
    );

    csm_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_valid(w_cmd_valid),
        .i_cmd      (w_cmd),
        .o_cmd_pop  (w_cmd_pop),
        .i_limit    (r_limit),
        .o_valid    (o_valid),
        .o_data     (o_data),
        .i_ready    (i_ready)
    );
endmodule
